// ===== src/bvrs_pkg.sv =====
// Shared constants, item types and the popcount function of the bit vector rank/select block.
package bvrs_pkg;

    // Storage geometry. WORD_BITS must be a power of two.
    localparam int WORD_BITS      = 64;
    localparam int CAPACITY_WORDS = 64;

    // Field widths of the input and result words.
    localparam int OP_W  = 4;
    localparam int POS_W = 13;
    localparam int ST_W  = 2;

    // Derived widths.
    localparam int WORD_LG  = $clog2(WORD_BITS);
    localparam int CAP_BITS = WORD_BITS * CAPACITY_WORDS;
    localparam int LEN_W    = ($clog2(CAP_BITS + 1) > POS_W) ? $clog2(CAP_BITS + 1) : POS_W;
    localparam int ADDR_W   = (CAPACITY_WORDS > 1) ? $clog2(CAPACITY_WORDS) : 1;
    localparam int WIDX_W   = $clog2(CAPACITY_WORDS + 1);
    localparam int PC_W     = WORD_LG + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ      = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SET       = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CLEAR     = OP_W'(2);
    localparam logic [OP_W-1:0] OP_APPEND    = OP_W'(3);
    localparam logic [OP_W-1:0] OP_RANK1     = OP_W'(4);
    localparam logic [OP_W-1:0] OP_RANK0     = OP_W'(5);
    localparam logic [OP_W-1:0] OP_SELECT1   = OP_W'(6);
    localparam logic [OP_W-1:0] OP_SELECT0   = OP_W'(7);
    localparam logic [OP_W-1:0] OP_RESET_LEN = OP_W'(8);

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = ST_W'(0);
    localparam logic [ST_W-1:0] ST_INDEX    = ST_W'(1);
    localparam logic [ST_W-1:0] ST_FULL     = ST_W'(2);
    localparam logic [ST_W-1:0] ST_NOTFOUND = ST_W'(3);

    // One input word.
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic             bit_value;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [POS_W-1:0] answer;
        logic [POS_W-1:0] length_after;
        logic [ST_W-1:0]  status;
    } t_result;

    // Number of ones in one stored word.
    function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] c;
        c = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            c = c + PC_W'(w[b]);
        end
        return c;
    endfunction

endpackage

// ===== src/bit_vector_rank_select_top.sv =====
// Bit vector with read, set, clear, append, rank and select under a small sequencer.
//
// A word is taken when start is high and busy is low; each word produces one result
// on o_result, marked by o_done for exactly one cycle, and the receiver cannot hold
// it off. Words that fail a length check, reset the length, carry an unused opcode,
// or ask for select of a zero count finish at once: the result shows in the next
// cycle and busy never rises. Read, set, clear and append pass through the S_RD and S_MOD
// states over the one read port of the word store (address, read, modify and write). Rank
// and select walk the stored words through one shared popcount unit, one word per cycle
// with the store read pipelined; select then scans the bits of the word that holds the
// answer one by one in S_SCAN. The store needs no clearing after reset: only bits below
// the length are ever read, and all of them have been written.
module bit_vector_rank_select_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bvrs_pkg::t_item   i_item,
    output logic              o_done,
    output bvrs_pkg::t_result o_result
);
    import bvrs_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;

    // Control registers.
    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_done, n_done;
    logic             r_pv, n_pv;

    // Datapath registers.
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [WORD_LG-1:0]   r_boff, n_boff;
    logic [OP_W-1:0]      r_op, n_op;
    logic                 r_bval, n_bval;
    logic [WIDX_W-1:0]    r_widx, n_widx;
    logic [WORD_BITS-1:0] r_pmask, n_pmask;
    logic [ADDR_W-1:0]    r_pidx, n_pidx;
    logic [LEN_W-1:0]     r_acc, n_acc;
    logic [LEN_W-1:0]     r_limit, n_limit;
    logic [LEN_W-1:0]     r_k, n_k;
    logic                 r_want0, n_want0;
    logic                 r_sel, n_sel;
    logic [WORD_BITS-1:0] r_scan, n_scan;
    logic [LEN_W-1:0]     r_need, n_need;
    logic [WORD_LG-1:0]   r_bit, n_bit;
    logic [ADDR_W-1:0]    r_sidx, n_sidx;
    t_result              r_res;

    // Word store and its registered read data.
    logic [WORD_BITS-1:0] r_store [CAPACITY_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    // Combinational signals.
    logic                 accept;
    logic [LEN_W-1:0]     pos_ext;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] onehot;
    logic [LEN_W-1:0]     base_next;
    logic [LEN_W-1:0]     bits_left;
    logic                 issue;
    logic [WORD_BITS-1:0] walk_mask;
    logic [WORD_BITS-1:0] wword;
    logic [PC_W-1:0]      pc;
    logic [LEN_W-1:0]     sum;
    logic [LEN_W-1:0]     n_ans;
    logic [ST_W-1:0]      n_st;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign pos_ext = LEN_W'(i_item.position);
    assign o_done  = r_done;
    assign o_result = r_res;

    // The walk reads the next word straight from its index; other reads use the latched address.
    assign rd_addr = (r_state == S_WALK) ? r_widx[ADDR_W-1:0] : r_addr;

    // Word walk: where the next word starts and which of its bits lie below the limit.
    assign base_next = LEN_W'({r_widx, {WORD_LG{1'b0}}});
    assign bits_left = r_limit - base_next;
    assign issue     = (base_next < r_limit);
    assign walk_mask = (bits_left >= LEN_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                     : ~({WORD_BITS{1'b1}} << bits_left[WORD_LG-1:0]);

    // Shared popcount on the word that arrived from the store.
    assign wword = (r_rdata ^ {WORD_BITS{r_want0}}) & r_pmask;
    assign pc    = popcount(wword);
    assign sum   = r_acc + LEN_W'(pc);

    assign onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_boff;

    // Sequencer and next-state logic.
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_done  = 1'b0;
        n_pv    = 1'b0;
        n_addr  = r_addr;
        n_boff  = r_boff;
        n_op    = r_op;
        n_bval  = r_bval;
        n_widx  = r_widx;
        n_pmask = r_pmask;
        n_pidx  = r_pidx;
        n_acc   = r_acc;
        n_limit = r_limit;
        n_k     = r_k;
        n_want0 = r_want0;
        n_sel   = r_sel;
        n_scan  = r_scan;
        n_need  = r_need;
        n_bit   = r_bit;
        n_sidx  = r_sidx;
        n_ans   = '0;
        n_st    = ST_OK;
        mem_we  = 1'b0;
        wdata   = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_item.opcode;
                    n_bval = i_item.bit_value;
                    unique case (i_item.opcode)
                        OP_READ, OP_SET, OP_CLEAR: begin
                            if (pos_ext >= r_len) begin
                                n_done = 1'b1;
                                n_st   = ST_INDEX;
                            end else begin
                                n_addr  = ADDR_W'(pos_ext >> WORD_LG);
                                n_boff  = pos_ext[WORD_LG-1:0];
                                n_state = S_RD;
                            end
                        end
                        OP_APPEND: begin
                            if (r_len >= LEN_W'(CAP_BITS)) begin
                                n_done = 1'b1;
                                n_st   = ST_FULL;
                            end else begin
                                n_addr  = ADDR_W'(r_len >> WORD_LG);
                                n_boff  = r_len[WORD_LG-1:0];
                                n_state = S_RD;
                            end
                        end
                        OP_RANK1, OP_RANK0: begin
                            if (pos_ext > r_len) begin
                                n_done = 1'b1;
                                n_st   = ST_INDEX;
                            end else begin
                                n_widx  = '0;
                                n_acc   = '0;
                                n_limit = pos_ext;
                                n_want0 = (i_item.opcode == OP_RANK0);
                                n_sel   = 1'b0;
                                n_state = S_WALK;
                            end
                        end
                        OP_SELECT1, OP_SELECT0: begin
                            // A count of zero is met by the empty prefix.
                            if (pos_ext == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_widx  = '0;
                                n_acc   = '0;
                                n_limit = r_len;
                                n_k     = pos_ext;
                                n_want0 = (i_item.opcode == OP_SELECT0);
                                n_sel   = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        OP_RESET_LEN: begin
                            n_len  = '0;
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_MOD;
            end

            S_MOD: begin
                unique case (r_op)
                    OP_READ: begin
                        n_ans = LEN_W'(r_rdata[r_boff]);
                    end
                    OP_SET: begin
                        mem_we = 1'b1;
                        wdata  = r_rdata | onehot;
                    end
                    OP_CLEAR: begin
                        mem_we = 1'b1;
                        wdata  = r_rdata & ~onehot;
                    end
                    OP_APPEND: begin
                        mem_we = 1'b1;
                        wdata  = r_bval ? (r_rdata | onehot) : (r_rdata & ~onehot);
                        n_len  = r_len + LEN_W'(1);
                    end
                    default: begin
                    end
                endcase
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_WALK: begin
                // Issue the next word while the previous one is counted.
                if (issue) begin
                    n_widx  = r_widx + WIDX_W'(1);
                    n_pv    = 1'b1;
                    n_pmask = walk_mask;
                    n_pidx  = r_widx[ADDR_W-1:0];
                end
                if (r_pv) begin
                    if (r_sel && (sum >= r_k)) begin
                        // The wanted bit lies in this word: scan it bit by bit.
                        n_scan  = wword;
                        n_need  = r_k - r_acc;
                        n_bit   = '0;
                        n_sidx  = r_pidx;
                        n_pv    = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        n_acc = sum;
                    end
                end else if (!issue) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_sel) begin
                        n_st = ST_NOTFOUND;
                    end else begin
                        // The walk already counted the wanted bit value, ones or zeros.
                        n_ans = r_acc;
                    end
                end
            end

            S_SCAN: begin
                n_scan = r_scan >> 1;
                n_bit  = r_bit + WORD_LG'(1);
                if (r_scan[0]) begin
                    if (r_need == LEN_W'(1)) begin
                        n_ans   = LEN_W'({r_sidx, r_bit}) + LEN_W'(1);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_need = r_need - LEN_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= n_done;
            r_pv    <= n_pv;
        end
    end

    // Datapath registers and the result word.
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_boff  <= n_boff;
        r_op    <= n_op;
        r_bval  <= n_bval;
        r_widx  <= n_widx;
        r_pmask <= n_pmask;
        r_pidx  <= n_pidx;
        r_acc   <= n_acc;
        r_limit <= n_limit;
        r_k     <= n_k;
        r_want0 <= n_want0;
        r_sel   <= n_sel;
        r_scan  <= n_scan;
        r_need  <= n_need;
        r_bit   <= n_bit;
        r_sidx  <= n_sidx;
        if (n_done) begin
            r_res.answer       <= POS_W'(n_ans);
            r_res.length_after <= POS_W'(n_len);
            r_res.status       <= n_st;
        end
    end

    // Word store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_addr] <= wdata;
        end
        r_rdata <= r_store[rd_addr];
    end

endmodule

// ===== src/bvrs_checker.sv =====
// Port-level checker of the bit vector rank/select block and its bind to the top level.
module bvrs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input bvrs_pkg::t_item   i_item,
    input logic              o_done,
    input bvrs_pkg::t_result o_result
);
    import bvrs_pkg::*;

    // An accepted word is either still in work or finished in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word neither busy nor done");

    // A result only follows an accepted word or a cycle of work.
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result without a word in work");

    // Any failed operation reports a zero answer.
    a_error_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |-> (o_result.answer == '0))
        else $error("failed operation with a nonzero answer");

    // A full store reports a length equal to the capacity.
    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_FULL)) |->
            (o_result.length_after == POS_W'(CAP_BITS)))
        else $error("store full reported below capacity");

endmodule

bind bit_vector_rank_select_top bvrs_checker u_bvrs_checker (.*);
